### hw/rtl/crtm_pkg.sv
// shared constants, types and helpers for the cell rule table matcher
// no dependencies; used by crtm_mask_store, the core and its checker
package crtm_pkg;

   // sizing of the rule set
   localparam int STATE_BITS     = 8;
   localparam int MAX_WORDS      = 8;
   localparam int RULE_WORD_BITS = 64;
   localparam int NUM_POS        = 9;
   localparam int VN_POS         = 5;

   // derived widths
   localparam int WORD_IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CNT_W      = $clog2(MAX_WORDS + 1);
   localparam int BIT_W      = (RULE_WORD_BITS > 1) ? $clog2(RULE_WORD_BITS) : 1;
   localparam int BANK_AW    = STATE_BITS + WORD_IDX_W;
   localparam int BANK_DEPTH = 1 << BANK_AW;
   localparam int OUT_DEPTH  = MAX_WORDS * RULE_WORD_BITS;
   localparam int OUT_AW     = $clog2(OUT_DEPTH);
   localparam int POS_W      = 4;

   // request modes
   localparam logic [1:0] MODE_MASK_WR = 2'd0;
   localparam logic [1:0] MODE_OUT_WR  = 2'd1;
   localparam logic [1:0] MODE_EVAL    = 2'd2;

   // register select (address bit 2)
   localparam logic REG_KIND  = 1'b0;
   localparam logic REG_WORDS = 1'b1;

   typedef logic [STATE_BITS-1:0]                     state_type;
   typedef logic [RULE_WORD_BITS-1:0]                 mask_type;
   typedef logic [NUM_POS-1:0][STATE_BITS-1:0]        state_vec_type;
   typedef logic [NUM_POS-1:0][RULE_WORD_BITS-1:0]    mask_vec_type;

   typedef struct packed {
      logic                  en;
      logic [POS_W-1:0]      pos;
      state_type             key;
      logic [WORD_IDX_W-1:0] word;
      mask_type              data;
   } mask_wr_type;

   typedef struct packed {
      logic                  en;
      logic [WORD_IDX_W-1:0] word;
      state_vec_type         states;
   } mask_rd_type;

   // index of the lowest set bit: isolate it, then encode the one-hot word
   function automatic logic [BIT_W-1:0] lowest_index(input mask_type v);
      mask_type         iso;
      logic [BIT_W-1:0] idx;
      iso = v & (~v + mask_type'(1));
      idx = '0;
      for (int i = 0; i < RULE_WORD_BITS; i++) begin
         if (iso[i]) begin
            idx = idx | BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### hw/rtl/crtm_mask_store.sv
// rule mask store: one bank per neighbor position, read in parallel
// depends on crtm_pkg
module crtm_mask_store (
   input  logic                  clock,
   input  crtm_pkg::mask_wr_type wr,
   input  crtm_pkg::mask_rd_type rd,
   output crtm_pkg::mask_vec_type rd_data
);

   for (genvar p = 0; p < crtm_pkg::NUM_POS; p++) begin : g_bank
      logic [crtm_pkg::RULE_WORD_BITS-1:0] bank_mem [crtm_pkg::BANK_DEPTH];
      logic [crtm_pkg::RULE_WORD_BITS-1:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr.en && (wr.pos == crtm_pkg::POS_W'(p))) begin
            bank_mem[{wr.key, wr.word}] <= wr.data;
         end
         if (rd.en) begin
            q_ff <= bank_mem[{rd.states[p], rd.word}];
         end
      end

      assign rd_data[p] = q_ff;
   end

endmodule

### hw/rtl/cell_rule_table_matcher_core.sv
// cell rule table matcher core: command port, csr port, rule output store
// depends on crtm_pkg and crtm_mask_store
//
//   channel  | handshake                           | payload
//   ---------+-------------------------------------+-----------------------------
//   request  | start & !busy                       | req_mode .. req_ring_neighbors
//   response | rsp_strobe, one cycle, no stall     | rsp_next_state, rsp_matched
//   csr      | psel & penable & pwrite (pready=1)  | paddr, pwdata / prdata
//
// mask and output writes take the accepting edge only; busy stays low
// an evaluate of n words in use runs bank read, hit stage and output store
// read to respond on a match, respond after the last word on a miss, and
// straight to respond if n is zero; busy is high until the strobe cycle ends
// the word loop issues one word per cycle to all nine mask banks at once,
// so the bank read port plus the and / lowest-bit stage set the pace
// synchronous reset clears the fsm and the csr registers; the mask and
// output stores are not cleared and must be written before use
module cell_rule_table_matcher_core (
   input  logic        clock,
   input  logic        reset,

   // command port
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_position,
   input  logic [7:0]  req_key_state,
   input  logic [2:0]  req_word_index,
   input  logic [5:0]  req_bit_index,
   input  logic [63:0] req_write_data,
   input  logic [7:0]  req_center_state,
   input  logic [63:0] req_ring_neighbors,

   // result word
   output logic        rsp_strobe,
   output logic [7:0]  rsp_next_state,
   output logic        rsp_matched,

   // csr port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CNT_W = crtm_pkg::CNT_W;
   localparam int WIW   = crtm_pkg::WORD_IDX_W;
   localparam int SB    = crtm_pkg::STATE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SCAN    = 3'b010,
      ST_RESPOND = 3'b100
   } ctl_state_type;

   ctl_state_type state_ff, state_in;

   // csr registers
   logic       kind_ff, kind_in;
   logic [3:0] words_ff, words_in;

   // per evaluate context
   logic                    eval_kind_ff, eval_kind_in;
   logic [CNT_W-1:0]        eval_words_ff, eval_words_in;
   logic [7:0]              center_ff, center_in;
   crtm_pkg::state_vec_type states_ff, states_in;
   logic [CNT_W-1:0]        issue_cnt_ff, issue_cnt_in;
   logic                    matched_ff, matched_in;

   // read stage (mask bank data lands next cycle)
   logic           rd_valid_ff, rd_valid_in;
   logic           rd_last_ff, rd_last_in;
   logic [WIW-1:0] rd_word_ff, rd_word_in;

   // hit stage
   crtm_pkg::mask_type hit_ff, hit_in;
   logic               hit_valid_ff, hit_valid_in;
   logic               hit_last_ff, hit_last_in;
   logic [WIW-1:0]     hit_word_ff, hit_word_in;

   // rule output store
   logic [7:0] out_mem [crtm_pkg::OUT_DEPTH];
   logic [7:0] out_q_ff;

   logic                    accept;
   logic                    eval_go;
   logic                    csr_wr;
   logic [CNT_W-1:0]        words_sat;
   crtm_pkg::state_vec_type load_states;
   logic                    issue_go;
   logic                    issue_last;
   logic                    found;
   logic                    out_we;
   logic [crtm_pkg::OUT_AW-1:0] out_wr_addr;
   logic [crtm_pkg::OUT_AW-1:0] out_rd_addr;
   crtm_pkg::mask_wr_type   mask_wr;
   crtm_pkg::mask_rd_type   mask_rd;
   crtm_pkg::mask_vec_type  mask_q;
   crtm_pkg::mask_type      and_word;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign eval_go = accept && (req_mode == crtm_pkg::MODE_EVAL);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   // csr readback
   always_comb begin
      unique case (paddr[2])
         crtm_pkg::REG_KIND:  prdata = {31'd0, kind_ff};
         crtm_pkg::REG_WORDS: prdata = {28'd0, words_ff};
         default:             prdata = '0;
      endcase
   end

   // words in use, saturated to the store size
   assign words_sat = (int'(words_ff) > crtm_pkg::MAX_WORDS) ?
                      CNT_W'(crtm_pkg::MAX_WORDS) : CNT_W'(words_ff);

   // per position states: center, then ring bytes; von neumann takes N, E, S, W
   always_comb begin
      load_states    = '0;
      load_states[0] = req_center_state[SB-1:0];
      for (int p = 1; p < crtm_pkg::NUM_POS; p++) begin
         if (kind_ff) begin
            load_states[p] = req_ring_neighbors[8*(p-1) +: SB];
         end else if (p < crtm_pkg::VN_POS) begin
            load_states[p] = req_ring_neighbors[16*(p-1) +: SB];
         end
      end
   end

   // mask writes go straight to the banks
   always_comb begin
      mask_wr.en   = accept && (req_mode == crtm_pkg::MODE_MASK_WR) &&
                     (int'(req_position) < crtm_pkg::NUM_POS) &&
                     (int'(req_word_index) < crtm_pkg::MAX_WORDS);
      mask_wr.pos  = req_position;
      mask_wr.key  = req_key_state[SB-1:0];
      mask_wr.word = WIW'(req_word_index);
      mask_wr.data = req_write_data[crtm_pkg::RULE_WORD_BITS-1:0];
   end

   // word sequencer: one word to all banks per cycle
   assign issue_go   = (state_ff == ST_SCAN) && (issue_cnt_ff < eval_words_ff);
   assign issue_last = ((issue_cnt_ff + CNT_W'(1)) == eval_words_ff);

   always_comb begin
      mask_rd.en     = issue_go;
      mask_rd.word   = issue_cnt_ff[WIW-1:0];
      mask_rd.states = states_ff;
   end

   crtm_mask_store u_mask_store (
      .clock   (clock),
      .wr      (mask_wr),
      .rd      (mask_rd),
      .rd_data (mask_q)
   );

   // and of the positions in use; unused ones pass all ones
   always_comb begin
      and_word = '1;
      for (int p = 0; p < crtm_pkg::NUM_POS; p++) begin
         if (eval_kind_ff || (p < crtm_pkg::VN_POS)) begin
            and_word = and_word & mask_q[p];
         end
      end
   end

   // first nonzero word wins, lowest bit picks the rule
   assign found       = hit_valid_ff && (hit_ff != '0);
   assign out_rd_addr = crtm_pkg::OUT_AW'(hit_word_ff) *
                        crtm_pkg::OUT_AW'(crtm_pkg::RULE_WORD_BITS) +
                        crtm_pkg::OUT_AW'(crtm_pkg::lowest_index(hit_ff));

   assign out_we      = accept && (req_mode == crtm_pkg::MODE_OUT_WR) &&
                        (int'(req_word_index) < crtm_pkg::MAX_WORDS) &&
                        (int'(req_bit_index) < crtm_pkg::RULE_WORD_BITS);
   assign out_wr_addr = crtm_pkg::OUT_AW'(req_word_index) *
                        crtm_pkg::OUT_AW'(crtm_pkg::RULE_WORD_BITS) +
                        crtm_pkg::OUT_AW'(req_bit_index);

   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_wr_addr] <= req_write_data[7:0];
      end
      if (found) begin
         out_q_ff <= out_mem[out_rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      words_in      = words_ff;
      eval_kind_in  = eval_kind_ff;
      eval_words_in = eval_words_ff;
      center_in     = center_ff;
      states_in     = states_ff;
      issue_cnt_in  = issue_cnt_ff;
      matched_in    = matched_ff;

      if (csr_wr) begin
         unique case (paddr[2])
            crtm_pkg::REG_KIND:  kind_in  = pwdata[0];
            crtm_pkg::REG_WORDS: words_in = pwdata[3:0];
            default: ;
         endcase
      end

      // pipeline stages advance only while scanning
      rd_valid_in  = issue_go;
      rd_last_in   = issue_last;
      rd_word_in   = issue_cnt_ff[WIW-1:0];
      hit_in       = and_word;
      hit_valid_in = (state_ff == ST_SCAN) && rd_valid_ff && !found;
      hit_last_in  = rd_last_ff;
      hit_word_in  = rd_word_ff;

      if (issue_go) begin
         issue_cnt_in = issue_cnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (eval_go) begin
               eval_kind_in  = kind_ff;
               eval_words_in = words_sat;
               center_in     = req_center_state;
               states_in     = load_states;
               issue_cnt_in  = '0;
               matched_in    = 1'b0;
               state_in      = (words_sat == '0) ? ST_RESPOND : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found) begin
               matched_in = 1'b1;
               state_in   = ST_RESPOND;
            end else if (hit_valid_ff && hit_last_ff) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= 1'b0;
         words_ff     <= '0;
         matched_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         hit_valid_ff <= 1'b0;
         issue_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         words_ff     <= words_in;
         matched_ff   <= matched_in;
         rd_valid_ff  <= rd_valid_in;
         hit_valid_ff <= hit_valid_in;
         issue_cnt_ff <= issue_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      eval_kind_ff  <= eval_kind_in;
      eval_words_ff <= eval_words_in;
      center_ff     <= center_in;
      states_ff     <= states_in;
      rd_last_ff    <= rd_last_in;
      rd_word_ff    <= rd_word_in;
      hit_ff        <= hit_in;
      hit_last_ff   <= hit_last_in;
      hit_word_ff   <= hit_word_in;
   end

   // result word: rule output on a match, else the full center state
   assign rsp_strobe     = (state_ff == ST_RESPOND);
   assign rsp_matched    = matched_ff;
   assign rsp_next_state = matched_ff ? out_q_ff : center_ff;

endmodule

### hw/rtl/crtm_checker.sv
// port-level checker for the cell rule table matcher core, bound to the top
// depends on crtm_pkg and cell_rule_table_matcher_core
module crtm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_mode,
   input logic       rsp_strobe
);

   // a result word only shows while the core is busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result word outside a busy period");

   // each result word lasts one cycle and ends the evaluate
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result word not followed by idle");

   // a result word follows scanning or an evaluate taken the cycle before
   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) ||
                      ($past(start) && ($past(req_mode) == crtm_pkg::MODE_EVAL))))
      else $error("result word without an evaluate");

   // an accepted evaluate makes the core busy
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == crtm_pkg::MODE_EVAL)) |=> busy)
      else $error("evaluate accepted but core not busy");

   // writes and ignored commands never hold the command port
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode != crtm_pkg::MODE_EVAL)) |=> !busy)
      else $error("write command made the core busy");

endmodule

bind cell_rule_table_matcher_core crtm_checker u_crtm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_mode   (req_mode),
   .rsp_strobe (rsp_strobe)
);
